// ----- hw/rtl/ufd_pkg.sv -----
// Shared types and constants for the disjoint-set union-find engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package ufd_pkg;

  localparam int IDX_W  = 10;  // element index and parent link width
  localparam int SIZE_W = 11;  // set size width
  localparam int CNT_W  = 11;  // element_count register width

  localparam logic [CNT_W-1:0] CNT_RESET  = 11'd1024;
  localparam logic             FUNC_FIND  = 1'b0;
  localparam logic             FUNC_UNITE = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;   // write one clearing entry, advance clear counter
    logic ld_req;     // capture request, start walk at first index
    logic rd_node;    // read parent and size at current node
    logic rd_up;      // read parent of the parent
    logic halve;      // repoint node to grandparent, move to grandparent
    logic save_a;     // keep first root and its size, start second walk
    logic save_b;     // keep second root and its size
    logic merge;      // link roots, add sizes, emit unite result
    logic emit_find;  // emit find result
    logic emit_err;   // emit error result
  } ufd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at its last entry
    logic is_root;    // parent just read equals the node
    logic req_err;    // request on the input ports has a bad index
    logic unite;      // captured request is a unite
  } ufd_sts_t;

endpackage : ufd_pkg

`default_nettype wire

// ----- hw/rtl/disjoint_set_union_find.sv -----
// Top level of the union-find engine: element_count register, controller, datapath.
// Depends on ufd_pkg, ufd_ctrl and ufd_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   request  | start & !busy        | in_func, in_first_index, in_second_index
//   result   | out_valid (1 cycle)  | out_root, out_merged, out_error
//   config   | cfg_valid & cfg_ready| cfg_element_count
//
// After reset a clearing pass writes every entry of both memories, one entry per
// cycle; busy stays high meanwhile. Config writes are always taken (cfg_ready is
// tied high).
// A request with a bad index is answered in the cycle after it is taken and does
// not raise busy. A find or a unite holds busy until its result is emitted. Each
// halving step reads the parent and then the grandparent, since the parent memory
// has a single read port. The result strobe lasts one cycle; the receiver cannot
// stall it.
`default_nettype none

module disjoint_set_union_find #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // request item
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_func,
  input  wire logic [ufd_pkg::IDX_W-1:0] in_first_index,
  input  wire logic [ufd_pkg::IDX_W-1:0] in_second_index,
  // result item
  output logic                           out_valid,
  output logic [ufd_pkg::IDX_W-1:0]      out_root,
  output logic                           out_merged,
  output logic                           out_error,
  // configuration
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ufd_pkg::CNT_W-1:0] cfg_element_count
);
  import ufd_pkg::*;

  logic [CNT_W-1:0] element_count_r;
  ufd_cmd_t         cmd;
  ufd_sts_t         sts;

  // Accept config at any time; the user writes only while idle
  assign cfg_ready = 1'b1;

  // Hold the element count; reset to the full range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      element_count_r <= cfg_element_count;
    end
  end

  // Sequence clearing, walks and merges
  ufd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Memories, walk registers and the result register
  ufd_datapath #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .elem_count      (element_count_r),
    .in_func         (in_func),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .out_valid       (out_valid),
    .out_root        (out_root),
    .out_merged      (out_merged),
    .out_error       (out_error)
  );

endmodule : disjoint_set_union_find

`default_nettype wire

// ----- hw/rtl/ufd_datapath.sv -----
// Datapath: parent and size memories, walk registers, result registers.
// Depends on ufd_pkg; driven by ufd_ctrl through ufd_cmd_t.
`default_nettype none

module ufd_datapath #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ufd_pkg::ufd_cmd_t         cmd,
  output ufd_pkg::ufd_sts_t              sts,
  input  wire logic [ufd_pkg::CNT_W-1:0] elem_count,
  input  wire logic                      in_func,
  input  wire logic [ufd_pkg::IDX_W-1:0] in_first_index,
  input  wire logic [ufd_pkg::IDX_W-1:0] in_second_index,
  output logic                           out_valid,
  output logic [ufd_pkg::IDX_W-1:0]      out_root,
  output logic                           out_merged,
  output logic                           out_error
);
  import ufd_pkg::*;

  localparam int AW = $clog2(NUM_ELEMENTS);

  logic [IDX_W-1:0]  parent_link_r [NUM_ELEMENTS];
  logic [SIZE_W-1:0] set_size_r    [NUM_ELEMENTS];

  logic [IDX_W-1:0]  par_q_r;
  logic [SIZE_W-1:0] size_q_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     node_r;
  logic [AW-1:0]     ib_r;
  logic              unite_r;
  logic [AW-1:0]     ra_r, rb_r;
  logic [SIZE_W-1:0] sa_r, sb_r;
  logic              out_valid_r, out_merged_r, out_error_r;
  logic [IDX_W-1:0]  out_root_r;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              par_we, size_we;
  logic [AW-1:0]     par_wa, size_wa;
  logic [IDX_W-1:0]  par_wd;
  logic [SIZE_W-1:0] size_wd;
  logic              a_ok, b_ok;
  logic              swap, differ;
  logic [AW-1:0]     winner, loser;

  // Index check against both the configured count and the memory depth
  assign a_ok = ({1'b0, in_first_index} < elem_count) &&
                (32'(in_first_index) < NUM_ELEMENTS);
  assign b_ok = ({1'b0, in_second_index} < elem_count) &&
                (32'(in_second_index) < NUM_ELEMENTS);

  assign differ = (ra_r != rb_r);
  assign swap   = (sa_r < sb_r);
  assign winner = swap ? rb_r : ra_r;
  assign loser  = swap ? ra_r : rb_r;

  always_comb begin
    sts.clr_last = (clr_cnt_r == AW'(NUM_ELEMENTS - 1));
    sts.is_root  = (AW'(par_q_r) == node_r);
    sts.req_err  = (in_func == FUNC_UNITE) ? !(a_ok && b_ok) : !a_ok;
    sts.unite    = unite_r;
  end

  // Read both memories at the same address
  assign rd_en   = cmd.rd_node | cmd.rd_up | cmd.halve;
  assign rd_addr = cmd.rd_node ? node_r : AW'(par_q_r);

  always_comb begin
    par_we  = 1'b0;
    par_wa  = node_r;
    par_wd  = par_q_r;
    size_we = 1'b0;
    size_wa = winner;
    size_wd = sa_r + sb_r;
    if (cmd.clr_step) begin
      par_we  = 1'b1;
      par_wa  = clr_cnt_r;
      par_wd  = IDX_W'(clr_cnt_r);
      size_we = 1'b1;
      size_wa = clr_cnt_r;
      size_wd = SIZE_W'(1);
    end else if (cmd.halve) begin
      par_we = 1'b1;
    end else if (cmd.merge && differ) begin
      par_we  = 1'b1;
      par_wa  = loser;
      par_wd  = IDX_W'(winner);
      size_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) parent_link_r[par_wa] <= par_wd;
    if (rd_en)  par_q_r <= parent_link_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (size_we) set_size_r[size_wa] <= size_wd;
    if (rd_en)   size_q_r <= set_size_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      out_valid_r <= cmd.emit_find | cmd.emit_err | cmd.merge;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      node_r  <= AW'(in_first_index);
      ib_r    <= AW'(in_second_index);
      unite_r <= in_func;
    end else if (cmd.halve) begin
      node_r <= AW'(par_q_r);
    end else if (cmd.save_a) begin
      node_r <= ib_r;
    end
    if (cmd.save_a) begin
      ra_r <= node_r;
      sa_r <= size_q_r;
    end
    if (cmd.save_b) begin
      rb_r <= node_r;
      sb_r <= size_q_r;
    end
    if (cmd.emit_err) begin
      out_root_r   <= '0;
      out_merged_r <= 1'b0;
      out_error_r  <= 1'b1;
    end else if (cmd.emit_find) begin
      out_root_r   <= IDX_W'(node_r);
      out_merged_r <= 1'b0;
      out_error_r  <= 1'b0;
    end else if (cmd.merge) begin
      out_root_r   <= IDX_W'(winner);
      out_merged_r <= differ;
      out_error_r  <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_root   = out_root_r;
  assign out_merged = out_merged_r;
  assign out_error  = out_error_r;

endmodule : ufd_datapath

`default_nettype wire

// ----- hw/rtl/ufd_ctrl.sv -----
// Controller state machine: clearing pass, root walks, merge sequencing.
// Depends on ufd_pkg; drives ufd_datapath through ufd_cmd_t.
`default_nettype none

module ufd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ufd_pkg::ufd_sts_t sts,
  output ufd_pkg::ufd_cmd_t      cmd
);
  import ufd_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_LINK  = 6'b001000,
    S_HALVE = 6'b010000,
    S_MERGE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    cmd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        second_nxt = 1'b0;
        if (start) begin
          if (sts.req_err) begin
            cmd.emit_err = 1'b1;
          end else begin
            cmd.ld_req = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_LINK;
      end
      S_LINK: begin
        if (!sts.is_root) begin
          cmd.rd_up = 1'b1;
          state_nxt = S_HALVE;
        end else if (second_r) begin
          cmd.save_b = 1'b1;
          state_nxt  = S_MERGE;
        end else if (sts.unite) begin
          cmd.save_a = 1'b1;
          second_nxt = 1'b1;
          state_nxt  = S_READ;
        end else begin
          cmd.emit_find = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_HALVE: begin
        cmd.halve = 1'b1;
        state_nxt = S_LINK;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule : ufd_ctrl

`default_nettype wire
